### hw/rtl/assert_macros.svh
// Assertion macros shared by the Taylor exponential RTL.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TEXP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TEXP_ASSERT(lbl, prop, msg)
`define TEXP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/texp_pkg.sv
// Constants, types and helper functions for the Taylor exponential pipeline.
// No dependencies; used by taylor_exp_evaluator_core.
package texp_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int MAX_TERMS = 32;
    localparam int NT_W      = 6;

    // Term magnitudes are held below 2^TERM_W.
    localparam int TERM_W  = 47;
    localparam int DMAG_W  = DATA_W;
    localparam int PL_W    = 2 * DMAG_W;
    localparam int PROD_W  = TERM_W + DMAG_W;
    localparam int OVF_W   = PROD_W - TERM_W - FRAC_BITS;

    // Division by the odd part of n is done in chunks of CW bits.
    localparam int ML      = $clog2(MAX_TERMS);
    localparam int CW      = 18;
    localparam int NCHUNK  = (TERM_W + ML + CW - 1) / CW;
    localparam int DIV_W   = NCHUNK * CW;
    localparam int NUM_W   = CW + ML;
    localparam int RSH     = NUM_W + ML;
    localparam int RECIP_W = RSH + 1;
    localparam int QP_W    = NUM_W + RECIP_W;

    // Pipeline layout: input stage, SPT stages per term from two upwards, final add.
    localparam int SPT     = 3 + NCHUNK;
    localparam int LAST_T  = SPT * (MAX_TERMS - 1);
    localparam int NPIPE   = LAST_T + 2;

    localparam int SUM_W   = TERM_W + $clog2(MAX_TERMS + 2) + 1;
    localparam int SMAG_W  = SUM_W - 1;
    localparam int SH_W    = SMAG_W - DATA_W;
    localparam int RPROD_W = SMAG_W + DATA_W;

    localparam int NUM_REGS = 3;
    localparam int ADDR_W   = $clog2(4 * NUM_REGS);

    localparam logic [DATA_W-1:0] CENTER_RST     = 32'd294912;
    localparam logic [DATA_W-1:0] CENTER_EXP_RST = 32'd5899363;
    localparam logic [NT_W-1:0]   NUM_TERMS_RST  = 6'd10;

    localparam logic [SUM_W-1:0]   SUM_ONE     = SUM_W'(1) << FRAC_BITS;
    localparam logic [RPROD_W-1:0] RES_POS_LIM = RPROD_W'(32'h7FFF_FFFF);
    localparam logic [RPROD_W-1:0] RES_NEG_LIM = RPROD_W'(32'h8000_0000);

    typedef enum logic [ADDR_W-3:0] {
        REG_CENTER,
        REG_CENTER_EXP,
        REG_NUM_TERMS
    } texp_reg_t;

    typedef struct packed {
        logic [DMAG_W-1:0] dmag;
        logic              dneg;
        logic [TERM_W-1:0] tmag;
        logic              tneg;
        logic [SUM_W-1:0]  sum;
        logic [PL_W-1:0]   prod_lo;
        logic [TERM_W-1:0] prod_hi;
        logic              clip;
        logic [DIV_W-1:0]  quo;
        logic [ML-1:0]     rem;
    } texp_lane_t;

    function automatic int trailing_zeros(input int n);
        int k;
        k = 0;
        for (int i = 0; i < 8; i++)
        begin
            if ((((n >> i) & 1) == 0) && (k == i))
            begin
                k = i + 1;
            end
        end
        return k;
    endfunction

    // Adds a sign-magnitude term to a two's complement running sum.
    function automatic logic [SUM_W-1:0] add_term(input logic [SUM_W-1:0]  sum,
                                                  input logic [TERM_W-1:0] tmag,
                                                  input logic              tneg);
        logic [SUM_W-1:0] ext;
        ext = SUM_W'(tmag);
        return tneg ? (sum - ext) : (sum + ext);
    endfunction

endpackage

### hw/rtl/taylor_exp_evaluator_core.sv
// Taylor-series exponential: each Q16.16 word x on the input stream yields one
// Q16.16 word of e^center * (1 + d + d^2/2! + ... + d^N/N!), with d = x - center
// and N = num_terms (capped at MAX_TERMS), clipped to the 32-bit range with tuser
// set when clipping happened. One word is accepted every cycle unless the output
// is stalled. Each word passes through the term chain, in which each term from
// two upwards takes six stages (two halves of the 47x32 multiply, a combine and
// overflow check, and three 18-bit chunks of the divide by n), followed by the
// final add, the multiply by e^center and the output clip. A stalled output
// holds the whole pipeline. Configuration is through the APB port (center at 0x0,
// center_exp at 0x4, num_terms at 0x8) and must only change while no word is in
// flight. Depends on texp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module taylor_exp_evaluator_core
    import texp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] sample
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] approx_value
    output logic              m_axis_tuser,   // [0] saturated
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [DATA_W-1:0] center_reg;
    logic [DATA_W-1:0] center_exp_reg;
    logic [NT_W-1:0]   num_terms_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg     <= CENTER_RST;
            center_exp_reg <= CENTER_EXP_RST;
            num_terms_reg  <= NUM_TERMS_RST;
        end
        else if (cfg_wr)
        begin
            case (texp_reg_t'(paddr[ADDR_W-1:2]))
                REG_CENTER:     center_reg     <= pwdata[DATA_W-1:0];
                REG_CENTER_EXP: center_exp_reg <= pwdata[DATA_W-1:0];
                REG_NUM_TERMS:  num_terms_reg  <= pwdata[NT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (texp_reg_t'(paddr[ADDR_W-1:2]))
            REG_CENTER:     prdata = center_reg;
            REG_CENTER_EXP: prdata = center_exp_reg;
            REG_NUM_TERMS:  prdata = 32'(num_terms_reg);
            default:        prdata = '0;
        endcase
    end

    // The whole pipeline moves together unless the output word is held.
    logic adv;
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    logic [NPIPE-1:0] valid_reg;
    logic [NPIPE-1:0] valid_next;
    texp_lane_t       pipe_reg  [0:NPIPE-1];
    texp_lane_t       pipe_next [0:NPIPE-1];

    assign valid_next = {valid_reg[NPIPE-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pipe_reg <= pipe_next;
        end
    end

    // Input stage: d and its magnitude; the first term is d itself.
    texp_lane_t      in_lane;
    logic [DATA_W:0] d_full;
    logic [DATA_W:0] d_neg_full;

    always_comb
    begin
        d_full     = {s_axis_tdata[DATA_W-1], s_axis_tdata} - {center_reg[DATA_W-1], center_reg};
        d_neg_full = -d_full;
        in_lane      = '0;
        in_lane.dneg = d_full[DATA_W];
        in_lane.dmag = d_full[DATA_W] ? d_neg_full[DMAG_W-1:0] : d_full[DMAG_W-1:0];
        in_lane.tmag = TERM_W'(in_lane.dmag);
        in_lane.tneg = in_lane.dneg;
        in_lane.sum  = SUM_ONE;
    end

    assign pipe_next[0] = in_lane;

    for (genvar n = 2; n <= MAX_TERMS; n++)
    begin : g_term
        localparam int KZ = trailing_zeros(n);
        localparam int M  = n >> KZ;
        localparam longint unsigned RECIP = ((64'd1 << RSH) + M - 1) / M;

        for (genvar s = 0; s < SPT; s++)
        begin : g_stage
            localparam int IDX = 1 + SPT * (n - 2) + s;
            texp_lane_t prv;
            texp_lane_t nxt;

            assign prv            = pipe_reg[IDX-1];
            assign pipe_next[IDX] = nxt;

            if (s == 0)
            begin : g_mul_lo
                // The previous term joins the sum here, if it is within the order.
                always_comb
                begin
                    nxt = prv;
                    if (int'(num_terms_reg) >= n - 1)
                    begin
                        nxt.sum = add_term(prv.sum, prv.tmag, prv.tneg);
                    end
                    nxt.prod_lo = PL_W'(prv.tmag[DMAG_W-1:0]) * PL_W'(prv.dmag);
                end
            end
            else if (s == 1)
            begin : g_mul_hi
                always_comb
                begin
                    nxt = prv;
                    nxt.prod_hi = TERM_W'(prv.tmag[TERM_W-1:DMAG_W]) * TERM_W'(prv.dmag);
                end
            end
            else if (s == 2)
            begin : g_combine
                logic [PROD_W-1:0] prod;
                logic [PROD_W-1:0] shifted;

                // The quotient overflows the term range exactly when the product
                // reaches n * 2^(TERM_W + FRAC_BITS).
                always_comb
                begin
                    prod     = {prv.prod_hi, {DMAG_W{1'b0}}} + PROD_W'(prv.prod_lo);
                    shifted  = prod >> (FRAC_BITS + KZ);
                    nxt      = prv;
                    nxt.clip = prod[PROD_W-1 -: OVF_W] >= OVF_W'(n);
                    nxt.quo  = shifted[DIV_W-1:0];
                    nxt.rem  = '0;
                end
            end
            else
            begin : g_chunk
                logic [NUM_W-1:0] num;
                logic [QP_W-1:0]  qprod;
                logic [CW-1:0]    qc;
                logic [NUM_W-1:0] back;
                logic [NUM_W-1:0] diff;

                // One chunk of long division by the odd part of n, most significant
                // first; the reciprocal is exact for every numerator below 2^NUM_W.
                always_comb
                begin
                    num      = {prv.rem, prv.quo[DIV_W-1 -: CW]};
                    qprod    = QP_W'(num) * QP_W'(RECIP);
                    qc       = qprod[RSH +: CW];
                    back     = NUM_W'(qc) * NUM_W'(M);
                    diff     = num - back;
                    nxt      = prv;
                    nxt.rem  = diff[ML-1:0];
                    nxt.quo  = {prv.quo[DIV_W-CW-1:0], qc};
                    if (s == SPT - 1)
                    begin
                        nxt.tmag = prv.clip ? {TERM_W{1'b1}} : nxt.quo[TERM_W-1:0];
                        nxt.tneg = prv.tneg ^ prv.dneg;
                    end
                end
            end
        end
    end

    // Final add of the highest term.
    texp_lane_t last_lane;
    texp_lane_t fin0_lane;

    assign last_lane = pipe_reg[NPIPE-2];

    always_comb
    begin
        fin0_lane = last_lane;
        if (int'(num_terms_reg) >= MAX_TERMS)
        begin
            fin0_lane.sum = add_term(last_lane.sum, last_lane.tmag, last_lane.tneg);
        end
    end

    assign pipe_next[NPIPE-1] = fin0_lane;

    // Scaling by e^center and clipping.
    logic [DATA_W-1:0] cexp_neg;
    logic [DATA_W-1:0] cmag;
    assign cexp_neg = -center_exp_reg;
    assign cmag     = center_exp_reg[DATA_W-1] ? cexp_neg : center_exp_reg;

    logic [3:0]         fin_valid_reg;
    logic [3:0]         fin_valid_next;
    logic [SUM_W-1:0]   sum_in;
    logic [SUM_W-1:0]   sum_neg;
    logic [SMAG_W-1:0]  f1_smag_reg,  f1_smag_next;
    logic               f1_rneg_reg,  f1_rneg_next;
    logic [PL_W-1:0]    f2_pl_reg,    f2_pl_next;
    logic [SH_W-1:0]    f2_sh_reg,    f2_sh_next;
    logic               f2_rneg_reg;
    logic [SMAG_W-1:0]  f3_ph_reg,    f3_ph_next;
    logic [PL_W-1:0]    f3_pl_reg;
    logic               f3_rneg_reg;
    logic [RPROD_W-1:0] f4_prod_reg,  f4_prod_next;
    logic               f4_rneg_reg;
    logic [RPROD_W-1:0] res_shifted;
    logic [RPROD_W-1:0] res_limit;
    logic               res_clip;
    logic [DATA_W-1:0]  res_mag;
    logic [DATA_W-1:0]  res_neg;
    logic [DATA_W-1:0]  out_data_reg, out_data_next;
    logic               out_sat_reg,  out_sat_next;
    logic               out_valid_reg;

    assign fin_valid_next = {fin_valid_reg[2:0], valid_reg[NPIPE-1]};

    always_comb
    begin
        sum_in       = pipe_reg[NPIPE-1].sum;
        sum_neg      = -sum_in;
        f1_smag_next = sum_in[SUM_W-1] ? sum_neg[SMAG_W-1:0] : sum_in[SMAG_W-1:0];
        f1_rneg_next = sum_in[SUM_W-1] ^ center_exp_reg[DATA_W-1];

        f2_pl_next   = PL_W'(f1_smag_reg[DATA_W-1:0]) * PL_W'(cmag);
        f2_sh_next   = f1_smag_reg[SMAG_W-1:DATA_W];

        f3_ph_next   = SMAG_W'(f2_sh_reg) * SMAG_W'(cmag);

        f4_prod_next = {f3_ph_reg, {DATA_W{1'b0}}} + RPROD_W'(f3_pl_reg);

        res_shifted   = f4_prod_reg >> FRAC_BITS;
        res_limit     = f4_rneg_reg ? RES_NEG_LIM : RES_POS_LIM;
        res_clip      = res_shifted > res_limit;
        res_mag       = res_clip ? res_limit[DATA_W-1:0] : res_shifted[DATA_W-1:0];
        res_neg       = -res_mag;
        out_data_next = f4_rneg_reg ? res_neg : res_mag;
        out_sat_next  = res_clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= fin_valid_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_smag_reg  <= f1_smag_next;
            f1_rneg_reg  <= f1_rneg_next;
            f2_pl_reg    <= f2_pl_next;
            f2_sh_reg    <= f2_sh_next;
            f2_rneg_reg  <= f1_rneg_reg;
            f3_ph_reg    <= f3_ph_next;
            f3_pl_reg    <= f2_pl_reg;
            f3_rneg_reg  <= f2_rneg_reg;
            f4_prod_reg  <= f4_prod_next;
            f4_rneg_reg  <= f3_rneg_reg;
            out_data_reg <= out_data_next;
            out_sat_reg  <= out_sat_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_sat_reg;

    `TEXP_ASSERT_NEXT(a_stall_holds_pipe, m_axis_tvalid && !m_axis_tready, $stable(valid_reg) && $stable(fin_valid_reg), "pipeline moved while the output word was held")
    `TEXP_ASSERT(a_sat_value, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 32'h7FFF_FFFF || m_axis_tdata == 32'h8000_0000), "saturated word is not a range limit")
    `TEXP_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, valid_reg[0], "accepted word did not enter the pipeline")

endmodule
